// File: rtl/smvp_pkg.sv
// Shared types and constants of the stereo mixer with master volume and peak meter.
// Used by every module in rtl; it depends on nothing else.
`default_nettype none

package smvp_pkg;

   localparam int FRACTION_BITS_DEF = 16;
   localparam int PEAK_STRIDE_DEF   = 32;
   localparam int HEADROOM_BITS_DEF = 4;

   localparam int SAMPLE_W  = 32;
   localparam int VOLUME_W  = 17;
   localparam int LEVEL_W   = 16;
   localparam int OUT_DEPTH = 8;

   typedef struct packed {
      logic valid;
      logic any_data;
      logic last_frame;
   } smvp_ctrl_type;

   typedef struct packed {
      logic                block_end;
      logic                frame_has_data;
      logic [LEVEL_W-1:0]  peak_right;
      logic [LEVEL_W-1:0]  peak_left;
      logic [SAMPLE_W-1:0] mix_right;
      logic [SAMPLE_W-1:0] mix_left;
   } smvp_result_type;

endpackage

`default_nettype wire

// File: rtl/smvp_lane.sv
// One channel lane: source accumulator, master gain multiply, floor shift,
// saturation and peak level. Depends on smvp_pkg.
`default_nettype none

module smvp_lane import smvp_pkg::*; #(
   parameter int FRACTION_BITS = FRACTION_BITS_DEF,
   parameter int HEADROOM_BITS = HEADROOM_BITS_DEF
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       accept,
   input  wire logic                       has_data,
   input  wire logic                       last_source,
   input  wire logic signed [SAMPLE_W-1:0] sample,
   input  wire logic [FRACTION_BITS:0]     volume,
   output logic        [SAMPLE_W-1:0]      mix,
   output logic        [LEVEL_W-1:0]       level
);

   localparam int ACC_W  = SAMPLE_W + HEADROOM_BITS;
   localparam int VOL_W  = FRACTION_BITS + 1;
   localparam int PROD_W = ACC_W + VOL_W + 1;
   localparam int MAG_W  = SAMPLE_W + 1;

   logic signed [ACC_W-1:0]  acc_ff, acc_in, sum;
   logic signed [ACC_W-1:0]  s1_sum_ff, s1_sum_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in, shifted;
   logic signed [VOL_W:0]    vol_s;
   logic [SAMPLE_W-1:0]      mix_ff, mix_in;
   logic [LEVEL_W-1:0]       level_ff, level_in;
   logic [PROD_W-SAMPLE_W:0] upper;
   logic [MAG_W-1:0]         mag, mag_sh;

   always_comb begin
      sum = acc_ff + (has_data ? {{HEADROOM_BITS{sample[SAMPLE_W-1]}}, sample} : ACC_W'(0));
      acc_in = acc_ff;
      s1_sum_in = s1_sum_ff;
      if (accept) begin
         acc_in = last_source ? ACC_W'(0) : sum;
         if (last_source) begin
            s1_sum_in = sum;
         end
      end

      vol_s = {1'b0, volume};
      prod_in = s1_sum_ff * vol_s;

      shifted = prod_ff >>> FRACTION_BITS;
      upper = shifted[PROD_W-1:SAMPLE_W-1];
      if (&upper || ~|upper) begin
         mix_in = shifted[SAMPLE_W-1:0];
      end else if (shifted[PROD_W-1]) begin
         mix_in = {1'b1, {(SAMPLE_W-1){1'b0}}};
      end else begin
         mix_in = {1'b0, {(SAMPLE_W-1){1'b1}}};
      end

      if (mix_in[SAMPLE_W-1]) begin
         mag = MAG_W'(0) - {1'b1, mix_in};
      end else begin
         mag = {1'b0, mix_in};
      end
      mag_sh = mag >> FRACTION_BITS;
      level_in = (|mag_sh[MAG_W-1:LEVEL_W]) ? {LEVEL_W{1'b1}} : mag_sh[LEVEL_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else begin
         acc_ff <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_sum_ff <= s1_sum_in;
      prod_ff   <= prod_in;
      mix_ff    <= mix_in;
      level_ff  <= level_in;
   end

   assign mix   = mix_ff;
   assign level = level_ff;

endmodule

`default_nettype wire

// File: rtl/smvp_merge.sv
// Merging stage: peak meter phase and max-hold, result assembly and output queue
// with credit count for the input side. Depends on smvp_pkg.
`default_nettype none

module smvp_merge import smvp_pkg::*; #(
   parameter int PEAK_STRIDE = PEAK_STRIDE_DEF
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            issue,
   input  wire smvp_ctrl_type   ctrl,
   input  wire logic [SAMPLE_W-1:0] mix_left,
   input  wire logic [SAMPLE_W-1:0] mix_right,
   input  wire logic [LEVEL_W-1:0]  level_left,
   input  wire logic [LEVEL_W-1:0]  level_right,
   input  wire logic            rsp_ready,
   output logic                 credit_ok,
   output logic                 rsp_valid,
   output smvp_result_type      rsp_word
);

   localparam int PH_W  = (PEAK_STRIDE > 1) ? $clog2(PEAK_STRIDE) : 1;
   localparam int PTR_W = $clog2(OUT_DEPTH);
   localparam int CNT_W = $clog2(OUT_DEPTH + 1);
   localparam logic [PH_W-1:0]  PH_LAST = PH_W'(PEAK_STRIDE - 1);
   localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(OUT_DEPTH);

   logic [PH_W-1:0]    phase_ff, phase_in;
   logic [LEVEL_W-1:0] hold_l_ff, hold_l_in, hold_r_ff, hold_r_in, new_l, new_r;
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   fill_ff, fill_in, pend_ff, pend_in;
   smvp_result_type    fifo_ff [OUT_DEPTH];
   smvp_result_type    word_in;
   logic               take, pop;

   always_comb begin
      take = (phase_ff == '0);
      new_l = (take && level_left > hold_l_ff) ? level_left : hold_l_ff;
      new_r = (take && level_right > hold_r_ff) ? level_right : hold_r_ff;

      word_in.block_end      = ctrl.last_frame;
      word_in.frame_has_data = ctrl.any_data;
      word_in.peak_left      = ctrl.last_frame ? new_l : '0;
      word_in.peak_right     = ctrl.last_frame ? new_r : '0;
      word_in.mix_left       = mix_left;
      word_in.mix_right      = mix_right;

      phase_in  = phase_ff;
      hold_l_in = hold_l_ff;
      hold_r_in = hold_r_ff;
      if (ctrl.valid) begin
         if (ctrl.last_frame) begin
            phase_in  = '0;
            hold_l_in = '0;
            hold_r_in = '0;
         end else begin
            phase_in  = (phase_ff == PH_LAST) ? PH_W'(0) : phase_ff + PH_W'(1);
            hold_l_in = new_l;
            hold_r_in = new_r;
         end
      end

      pop       = rsp_valid & rsp_ready;
      wr_ptr_in = ctrl.valid ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      fill_in   = fill_ff + CNT_W'(ctrl.valid) - CNT_W'(pop);
      pend_in   = pend_ff + CNT_W'(issue) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= '0;
         hold_l_ff <= '0;
         hold_r_ff <= '0;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
         pend_ff   <= '0;
      end else begin
         phase_ff  <= phase_in;
         hold_l_ff <= hold_l_in;
         hold_r_ff <= hold_r_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
         pend_ff   <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.valid) begin
         fifo_ff[wr_ptr_ff] <= word_in;
      end
   end

   assign credit_ok = (pend_ff < DEPTH_C);
   assign rsp_valid = (fill_ff != '0);
   assign rsp_word  = fifo_ff[rd_ptr_ff];

endmodule

`default_nettype wire

// File: rtl/stereo_mixer_volume_peak_core.sv
// Stereo mixer core: a left and a right lane sum source pairs, apply the master
// volume and saturate; a merging stage runs the block peak meter and output queue.
// A result word is registered through the lane sum, product and mix stages, then queued.
// Throughput: one input word per cycle, bounded by an 8-entry output credit count.
// Reset (synchronous, active high) clears accumulators, peak holds, phase and queue
// and sets the master volume to unity. Depends on smvp_pkg, smvp_lane, smvp_merge.
`default_nettype none

module stereo_mixer_volume_peak_core import smvp_pkg::*; #(
   parameter int FRACTION_BITS = FRACTION_BITS_DEF,
   parameter int PEAK_STRIDE   = PEAK_STRIDE_DEF,
   parameter int HEADROOM_BITS = HEADROOM_BITS_DEF
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_tvalid,
   output logic                     req_tready,
   input  wire logic [63:0]         req_tdata,  // left_sample, right_sample
   input  wire logic [1:0]          req_tuser,  // source_has_data, last_frame
   input  wire logic                req_tlast,
   output logic                     rsp_tvalid,
   input  wire logic                rsp_tready,
   output logic [95:0]              rsp_tdata,  // mix_left, mix_right, peak_left, peak_right
   output logic [0:0]               rsp_tuser,  // frame_has_data
   output logic                     rsp_tlast,
   input  wire logic                csr_valid,
   output logic                     csr_ready,
   input  wire logic [VOLUME_W-1:0] csr_data
);

   localparam int VOL_W = FRACTION_BITS + 1;
   localparam int CMP_W = (VOL_W > VOLUME_W) ? VOL_W : VOLUME_W;
   localparam logic [VOL_W-1:0] UNITY = {1'b1, {FRACTION_BITS{1'b0}}};

   logic [VOL_W-1:0] volume_ff, volume_in;
   logic             any_ff, any_in;
   smvp_ctrl_type    s1_ctrl_ff, s1_ctrl_in, s2_ctrl_ff, s3_ctrl_ff;
   logic             accept, issue, credit_ok;
   logic [SAMPLE_W-1:0] mix_l, mix_r;
   logic [LEVEL_W-1:0]  level_l, level_r;
   smvp_result_type  rsp_word;

   assign req_tready = credit_ok & ~reset;
   assign csr_ready  = ~reset;
   assign accept     = req_tvalid & req_tready;
   assign issue      = accept & req_tlast;

   always_comb begin
      volume_in = volume_ff;
      if (csr_valid && csr_ready) begin
         if (CMP_W'(csr_data) > CMP_W'(UNITY)) begin
            volume_in = UNITY;
         end else begin
            volume_in = VOL_W'(csr_data);
         end
      end

      any_in = any_ff;
      if (accept) begin
         any_in = req_tlast ? 1'b0 : (any_ff | req_tuser[0]);
      end

      s1_ctrl_in.valid      = issue;
      s1_ctrl_in.any_data   = any_ff | req_tuser[0];
      s1_ctrl_in.last_frame = req_tuser[1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         volume_ff  <= UNITY;
         any_ff     <= 1'b0;
         s1_ctrl_ff <= '0;
         s2_ctrl_ff <= '0;
         s3_ctrl_ff <= '0;
      end else begin
         volume_ff  <= volume_in;
         any_ff     <= any_in;
         s1_ctrl_ff <= s1_ctrl_in;
         s2_ctrl_ff <= s1_ctrl_ff;
         s3_ctrl_ff <= s2_ctrl_ff;
      end
   end

   smvp_lane #(
      .FRACTION_BITS (FRACTION_BITS),
      .HEADROOM_BITS (HEADROOM_BITS)
   ) u_lane_left (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .has_data    (req_tuser[0]),
      .last_source (req_tlast),
      .sample      (req_tdata[31:0]),
      .volume      (volume_ff),
      .mix         (mix_l),
      .level       (level_l)
   );

   smvp_lane #(
      .FRACTION_BITS (FRACTION_BITS),
      .HEADROOM_BITS (HEADROOM_BITS)
   ) u_lane_right (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .has_data    (req_tuser[0]),
      .last_source (req_tlast),
      .sample      (req_tdata[63:32]),
      .volume      (volume_ff),
      .mix         (mix_r),
      .level       (level_r)
   );

   smvp_merge #(
      .PEAK_STRIDE (PEAK_STRIDE)
   ) u_merge (
      .clock       (clock),
      .reset       (reset),
      .issue       (issue),
      .ctrl        (s3_ctrl_ff),
      .mix_left    (mix_l),
      .mix_right   (mix_r),
      .level_left  (level_l),
      .level_right (level_r),
      .rsp_ready   (rsp_tready),
      .credit_ok   (credit_ok),
      .rsp_valid   (rsp_tvalid),
      .rsp_word    (rsp_word)
   );

   assign rsp_tdata = {rsp_word.peak_right, rsp_word.peak_left,
                       rsp_word.mix_right, rsp_word.mix_left};
   assign rsp_tuser = rsp_word.frame_has_data;
   assign rsp_tlast = rsp_word.block_end;

`ifndef SYNTH
   a_issue_origin: assert property (@(posedge clock) disable iff (reset)
      s1_ctrl_ff.valid |-> $past(req_tvalid && req_tready && req_tlast))
      else $error("stage one holds a frame that was never issued");

   a_silent_frame: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata[63:0] == 64'd0)
      else $error("frame without source data has a nonzero mix");

   a_peak_outside_end: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> rsp_tdata[95:64] == 32'd0)
      else $error("peaks reported outside block end");
`endif

endmodule

`default_nettype wire

// File: test/stereo_mixer_volume_peak_core_tb.sv
// Self-checking testbench for stereo_mixer_volume_peak_core: directed and random frames,
// master volume changes and output back-pressure, checked against an in-bench predictor.
// Depends on smvp_pkg and the core RTL only.
module stereo_mixer_volume_peak_core_tb;
   import smvp_pkg::*;

   localparam int  ACC_W       = SAMPLE_W + HEADROOM_BITS_DEF;
   localparam int  UNITY_GAIN  = 1 << FRACTION_BITS_DEF;
   localparam int  CYCLE_LIMIT = 400000;
   localparam int  DRAIN_WAIT  = 12;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [63:0]         req_tdata = '0;
   logic [1:0]          req_tuser = '0;
   logic                req_tlast = 1'b0;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [95:0]         rsp_tdata;
   logic [0:0]          rsp_tuser;
   logic                rsp_tlast;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [VOLUME_W-1:0] csr_data = '0;

   logic [ACC_W-1:0]    mix_sum_left;
   logic [ACC_W-1:0]    mix_sum_right;
   logic                frame_any_data;
   int unsigned         meter_phase;
   logic [LEVEL_W-1:0]  hold_left;
   logic [LEVEL_W-1:0]  hold_right;
   logic [VOLUME_W-1:0] master_gain;

   smvp_result_type     mix_expected[$];
   int                  errors = 0;
   int                  cycle_count = 0;
   int                  send_gap_pct = 0;
   int                  recv_gap_pct = 0;
   int                  stall_left = 0;

   stereo_mixer_volume_peak_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("stereo_mixer_volume_peak_core verification failed");
         $finish;
      end
   end

   always @(negedge clock) begin
      if (stall_left > 0) stall_left--;
      rsp_tready = (stall_left == 0) && ($urandom_range(0, 99) >= recv_gap_pct);
   end

   function automatic logic [SAMPLE_W-1:0] scaled_mix(input logic signed [ACC_W-1:0] sum);
      longint prod;
      prod = longint'(sum) * longint'(master_gain);
      prod = prod >>> FRACTION_BITS_DEF;
      if (prod > 64'sd2147483647) prod = 64'sd2147483647;
      if (prod < -64'sd2147483648) prod = -64'sd2147483648;
      return prod[SAMPLE_W-1:0];
   endfunction

   function automatic logic [LEVEL_W-1:0] peak_level(input logic signed [SAMPLE_W-1:0] s);
      longint mag;
      mag = longint'(s);
      if (mag < 0) mag = -mag;
      mag = mag >>> FRACTION_BITS_DEF;
      return (mag > 65535) ? 16'hFFFF : mag[LEVEL_W-1:0];
   endfunction

   function automatic logic [SAMPLE_W-1:0] rand_sample();
      case ($urandom_range(0, 7))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return $urandom_range(0, 65535) - 32768;
         default: return $urandom;
      endcase
   endfunction

   task automatic predict_word(input logic [SAMPLE_W-1:0] left, right,
                               input logic has_data, last_src, last_frm);
      smvp_result_type res;
      logic [LEVEL_W-1:0] lev_left, lev_right;
      if (has_data) begin
         mix_sum_left   = mix_sum_left + {{HEADROOM_BITS_DEF{left[31]}}, left};
         mix_sum_right  = mix_sum_right + {{HEADROOM_BITS_DEF{right[31]}}, right};
         frame_any_data = 1'b1;
      end
      if (last_src) begin
         res = '0;
         res.mix_left       = scaled_mix(mix_sum_left);
         res.mix_right      = scaled_mix(mix_sum_right);
         res.frame_has_data = frame_any_data;
         if (meter_phase == 0) begin
            lev_left  = peak_level(res.mix_left);
            lev_right = peak_level(res.mix_right);
            if (lev_left > hold_left) hold_left = lev_left;
            if (lev_right > hold_right) hold_right = lev_right;
         end
         if (last_frm) begin
            res.peak_left  = hold_left;
            res.peak_right = hold_right;
            res.block_end  = 1'b1;
            hold_left      = '0;
            hold_right     = '0;
            meter_phase    = 0;
         end else begin
            meter_phase = (meter_phase + 1) % PEAK_STRIDE_DEF;
         end
         mix_expected = {mix_expected, res};
         mix_sum_left   = '0;
         mix_sum_right  = '0;
         frame_any_data = 1'b0;
      end
   endtask

   task automatic send_word(input logic [SAMPLE_W-1:0] left, right,
                            input logic has_data, last_src, last_frm);
      while ($urandom_range(0, 99) < send_gap_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = {right, left};
      req_tuser  = {last_frm, has_data};
      req_tlast  = last_src;
      do @(posedge clock); while (!req_tready);
      predict_word(left, right, has_data, last_src, last_frm);
      @(negedge clock);
   endtask

   task automatic send_frame(input int sources, input logic ends_block);
      for (int i = 0; i < sources; i++) begin
         send_word(rand_sample(), rand_sample(), $urandom_range(0, 4) != 0, i == sources - 1,
                   (i == sources - 1) ? ends_block : 1'($urandom_range(0, 1)));
      end
   endtask

   task automatic drain_results();
      req_tvalid = 1'b0;
      while (mix_expected.size() != 0) @(negedge clock);
      repeat (DRAIN_WAIT) @(negedge clock);
   endtask

   task automatic write_volume(input logic [VOLUME_W-1:0] value);
      drain_results();
      csr_valid = 1'b1;
      csr_data  = value;
      do @(posedge clock); while (!csr_ready);
      master_gain = (value > UNITY_GAIN) ? VOLUME_W'(UNITY_GAIN) : value;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic test_directed_extremes();
      send_gap_pct = 0;
      recv_gap_pct = 0;
      send_word(32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 1'b1, 1'b0);
      send_word(32'h1234_5678, 32'h9ABC_DEF0, 1'b0, 1'b1, 1'b0);
      send_word(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, 1'b0, 1'b1);
      send_word(32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 1'b1, 1'b0);
      send_word(32'h8000_0000, 32'h8000_0000, 1'b1, 1'b0, 1'b0);
      send_word(32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 1'b0, 1'b1);
      send_word(32'h8000_0000, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1);
      send_word(32'h0000_0000, 32'h0000_0000, 1'b0, 1'b1, 1'b1);
   endtask

   task automatic test_accumulator_wrap();
      for (int i = 0; i < 17; i++) begin
         send_word(32'h8000_0000, 32'h7FFF_FFFF, 1'b1, i == 16, i == 16);
      end
      drain_results();
   endtask

   task automatic test_volume_settings();
      logic [VOLUME_W-1:0] levels[8];
      levels = '{17'd0, 17'd1, 17'd32768, 17'd65535, 17'h1FFFF, 17'd98304,
                 17'($urandom_range(0, 65536)), 17'd65536};
      send_gap_pct = 10;
      recv_gap_pct = 10;
      foreach (levels[i]) begin
         write_volume(levels[i]);
         send_word(32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 1'b1, 1'b0);
         for (int f = 0; f < 6; f++) send_frame($urandom_range(1, 4), f == 5);
      end
   endtask

   task automatic test_backpressure();
      send_gap_pct = 0;
      recv_gap_pct = 0;
      stall_left   = 300;
      for (int i = 0; i < 100; i++) send_frame(1, $urandom_range(0, 39) == 0);
      drain_results();
   endtask

   task automatic test_random_frames(input int send_pct, recv_pct, words);
      int sent;
      send_gap_pct = send_pct;
      recv_gap_pct = recv_pct;
      sent = 0;
      while (sent < words) begin
         if ($urandom_range(0, 9) == 0) begin
            send_word($urandom, $urandom, 1'b0, 1'b0, 1'($urandom_range(0, 1)));
            sent++;
         end else begin
            int sources;
            sources = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 4);
            send_frame(sources, $urandom_range(0, 39) == 0);
            sent += sources;
         end
      end
   endtask

   always @(posedge clock) begin
      smvp_result_type want;
      if (rsp_tvalid && rsp_tready) begin
         if (mix_expected.size() == 0) begin
            $display("%0t: result word with no expectation, actual %h", $time, rsp_tdata);
            errors++;
         end else begin
            want = mix_expected.pop_front();
            check_field("mix_left", want.mix_left, rsp_tdata[31:0]);
            check_field("mix_right", want.mix_right, rsp_tdata[63:32]);
            check_field("peak_left", 32'(want.peak_left), 32'(rsp_tdata[79:64]));
            check_field("peak_right", 32'(want.peak_right), 32'(rsp_tdata[95:80]));
            check_field("frame_has_data", 32'(want.frame_has_data), 32'(rsp_tuser[0]));
            check_field("block_end", 32'(want.block_end), 32'(rsp_tlast));
         end
      end
   end

   task automatic check_field(input string name, input logic [31:0] want, got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
         errors++;
      end
   endtask

   initial begin
      mix_sum_left   = '0;
      mix_sum_right  = '0;
      frame_any_data = 1'b0;
      meter_phase    = 0;
      hold_left      = '0;
      hold_right     = '0;
      master_gain    = VOLUME_W'(UNITY_GAIN);
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      test_directed_extremes();
      test_accumulator_wrap();
      test_volume_settings();
      test_backpressure();
      write_volume(17'($urandom_range(32768, 65536)));
      test_random_frames(10, 61, 330);
      drain_results();
      write_volume(17'd65536);
      test_random_frames(61, 10, 330);
      test_random_frames(0, 0, 330);

      req_tvalid = 1'b0;
      while (mix_expected.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (mix_expected.size() != 0) begin
         $display("%0t: %0d expected result words never arrived", $time, mix_expected.size());
         errors++;
      end
      if (errors == 0) begin
         $display("stereo_mixer_volume_peak_core verification clean");
      end else begin
         $display("stereo_mixer_volume_peak_core verification failed");
      end
      $finish;
   end

endmodule
